[src/lpkd_pkg.sv]
// Shared types, constants and helpers for the length-prefixed key decoder.
`timescale 1ns / 1ps
`default_nettype none

package lpkd_pkg;

  localparam int unsigned MaxKeyLen  = 7;
  localparam int unsigned PrefixBits = 3;
  localparam int unsigned TableDepth = 256;
  localparam int unsigned TotalKeys  = (1 << (MaxKeyLen + 1)) - 2 - MaxKeyLen;

  localparam int unsigned CharW = 8;
  localparam int unsigned AddrW = $clog2(TableDepth);
  localparam int unsigned LenW  = 3;
  localparam int unsigned KeyW  = MaxKeyLen;

  typedef logic [CharW-1:0] char_t;
  typedef logic [AddrW-1:0] addr_t;
  typedef logic [LenW-1:0]  len_t;
  typedef logic [KeyW-1:0]  key_t;

  typedef enum logic {
    OP_HEADER = 1'b0,
    OP_CODE   = 1'b1
  } op_e;

  // Table write from a header word
  typedef struct packed {
    logic  we;
    addr_t addr;
    char_t data;
  } tbl_wr_t;

  // Result request from the bit decoder
  typedef struct packed {
    logic  emit;
    logic  eom;
    logic  hit;
    addr_t addr;
  } lookup_t;

  // Mask of len low ones
  function automatic key_t key_mask(input len_t len);
    key_t m;
    for (int i = 0; i < KeyW; i++) begin
      m[i] = (i < int'(len));
    end
    return m;
  endfunction

endpackage

`default_nettype wire

[src/length_prefixed_key_decoder_core.sv]
// Top level: input handshake, bit decoder, key table and result register.
// A word that completes a key or the end prefix gives its result in the
// cycle after acceptance; a hit reads the key table's registered read port.
// Throughput: one input word per cycle; a held result does not block input
// while the consumer takes it in the same cycle.
// Reset (rst_ni low, asynchronous): empty table, prefix state, no result.
// Key table contents are not cleared; entries beyond the fill count read 0.
`timescale 1ns / 1ps
`default_nettype none

module length_prefixed_key_decoder_core
  import lpkd_pkg::*;
(
  input  wire   clk_i,
  input  wire   rst_ni,
  input  wire   in_valid_i,
  output logic  in_ready_o,
  input  wire   op_i,
  input  char_t header_char_i,
  input  wire   code_bit_i,
  output logic  out_valid_o,
  input  wire   out_ready_i,
  output char_t decoded_char_o,
  output logic  end_of_message_o
);

  logic    accept;
  tbl_wr_t wr;
  lookup_t lookup;
  char_t   rdata;

  logic out_valid_q, out_valid_d;
  logic hit_q, hit_d;
  logic eom_q, eom_d;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  lpkd_bit_decoder u_dec (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .op_i          (op_e'(op_i)),
    .header_char_i (header_char_i),
    .code_bit_i    (code_bit_i),
    .wr_o          (wr),
    .lookup_o      (lookup)
  );

  lpkd_key_table u_tbl (
    .clk_i   (clk_i),
    .wr_i    (wr),
    .re_i    (lookup.emit && lookup.hit),
    .raddr_i (lookup.addr),
    .rdata_o (rdata)
  );

  // Load a new result word or drop the taken one
  always_comb begin
    out_valid_d = out_valid_q;
    hit_d       = hit_q;
    eom_d       = eom_q;
    if (lookup.emit) begin
      out_valid_d = 1'b1;
      hit_d       = lookup.hit;
      eom_d       = lookup.eom;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q <= hit_d;
    eom_q <= eom_d;
  end

  assign out_valid_o      = out_valid_q;
  assign decoded_char_o   = hit_q ? rdata : '0;
  assign end_of_message_o = eom_q;

endmodule

`default_nettype wire

[src/lpkd_key_table.sv]
// Key table memory: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module lpkd_key_table
  import lpkd_pkg::*;
(
  input  wire     clk_i,
  input  tbl_wr_t wr_i,
  input  wire     re_i,
  input  addr_t   raddr_i,
  output char_t   rdata_o
);

  char_t mem [TableDepth];
  char_t rdata_q;

  // Write header words
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  // Read on lookup, hold otherwise
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[src/lpkd_bit_decoder.sv]
// Header fill counter and prefix/key bit decoder state.
`timescale 1ns / 1ps
`default_nettype none

module lpkd_bit_decoder
  import lpkd_pkg::*;
(
  input  wire     clk_i,
  input  wire     rst_ni,
  input  wire     accept_i,
  input  op_e     op_i,
  input  char_t   header_char_i,
  input  wire     code_bit_i,
  output tbl_wr_t wr_o,
  output lookup_t lookup_o
);

  addr_t fill_q, fill_d;
  logic  active_q, active_d;
  logic  in_seg_q, in_seg_d;
  len_t  klen_q, klen_d;
  len_t  taken_q, taken_d;
  key_t  acc_q, acc_d;

  key_t  acc_n;
  len_t  taken_n;
  key_t  ones;
  key_t  value;
  len_t  plen;

  always_comb begin
    fill_d   = fill_q;
    active_d = active_q;
    in_seg_d = in_seg_q;
    klen_d   = klen_q;
    taken_d  = taken_q;
    acc_d    = acc_q;
    wr_o     = '{we: 1'b0, addr: fill_q, data: header_char_i};
    lookup_o = '{emit: 1'b0, eom: 1'b0, hit: 1'b0, addr: '0};

    acc_n   = {acc_q[KeyW-2:0], code_bit_i};
    taken_n = taken_q + len_t'(1);
    ones    = key_mask(klen_q);
    value   = acc_n & ones;
    plen    = acc_n[LenW-1:0];

    if (accept_i) begin
      if (op_i == OP_HEADER) begin
        // Load the next table entry while not decoding, until the table is full
        if (!active_q && (fill_q < addr_t'(TotalKeys))) begin
          wr_o.we = 1'b1;
          fill_d  = fill_q + addr_t'(1);
        end
      end else begin
        active_d = 1'b1;
        acc_d    = acc_n;
        taken_d  = taken_n;
        if (!in_seg_q) begin
          // Length prefix
          if (taken_n >= len_t'(PrefixBits)) begin
            if (plen == '0) begin
              lookup_o.emit = 1'b1;
              lookup_o.eom  = 1'b1;
              fill_d   = '0;
              active_d = 1'b0;
              in_seg_d = 1'b0;
              klen_d   = '0;
              taken_d  = '0;
              acc_d    = '0;
            end else begin
              klen_d   = (plen > len_t'(MaxKeyLen)) ? len_t'(MaxKeyLen) : plen;
              in_seg_d = 1'b1;
              taken_d  = '0;
              acc_d    = '0;
            end
          end
        end else if (taken_n >= klen_q) begin
          // Complete key: all ones closes the segment
          taken_d = '0;
          acc_d   = '0;
          if (value == ones) begin
            in_seg_d = 1'b0;
            klen_d   = '0;
          end else begin
            lookup_o.emit = 1'b1;
            lookup_o.addr = addr_t'({1'b0, ones}) - addr_t'(klen_q) + addr_t'(value);
            lookup_o.hit  = (lookup_o.addr < fill_q);
          end
        end
      end
    end
  end

  // Hold decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      active_q <= 1'b0;
      in_seg_q <= 1'b0;
      klen_q   <= '0;
      taken_q  <= '0;
      acc_q    <= '0;
    end else begin
      fill_q   <= fill_d;
      active_q <= active_d;
      in_seg_q <= in_seg_d;
      klen_q   <= klen_d;
      taken_q  <= taken_d;
      acc_q    <= acc_d;
    end
  end

endmodule

`default_nettype wire

[tb/tb_length_prefixed_key_decoder_core.sv]
// Testbench for the length-prefixed key decoder core: directed and random words, scoreboard check.
`timescale 1ns / 1ps

module tb_length_prefixed_key_decoder_core;
  import lpkd_pkg::*;

  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned RandomItems   = 400;
  localparam int unsigned DrainCycles   = 8;

  typedef struct packed {
    char_t ch;
    logic  eom;
  } char_result_t;

  // Tracks table and prefix/key state, holds expected characters in order
  class key_decode_tracker;
    char_t        key_chars[TableDepth];
    int unsigned  fill;
    bit           active;
    bit           in_seg;
    int unsigned  key_len;
    int unsigned  taken;
    key_t         acc;
    char_result_t expected_chars[$];
    int unsigned  errors;
    int unsigned  results;
    int unsigned  eoms;

    function new();
      fill    = 0;
      active  = 1'b0;
      errors  = 0;
      results = 0;
      eoms    = 0;
      clear_key_state();
    endfunction

    function void clear_key_state();
      in_seg  = 1'b0;
      key_len = 0;
      taken   = 0;
      acc     = '0;
    endfunction

    // Advance the decoder by one accepted word
    function void note_word(op_e op, char_t hc, logic b);
      char_result_t r;
      int unsigned  ones;
      int unsigned  value;
      int unsigned  idx;
      if (op == OP_HEADER) begin
        // Fill the table only before decoding starts; drop overflow
        if (!active && fill < TotalKeys && fill < TableDepth) begin
          key_chars[fill] = hc;
          fill++;
        end
        return;
      end
      active = 1'b1;
      acc    = {acc[KeyW-2:0], b};
      taken++;
      if (!in_seg) begin
        if (taken < PrefixBits) return;
        if (acc[LenW-1:0] == '0) begin
          // End of message: marker result, then start over with an empty table
          r.ch  = '0;
          r.eom = 1'b1;
          expected_chars.push_back(r);
          fill   = 0;
          active = 1'b0;
          clear_key_state();
          return;
        end
        key_len = acc[LenW-1:0];
        if (key_len > MaxKeyLen) key_len = MaxKeyLen;
        in_seg = 1'b1;
        taken  = 0;
        acc    = '0;
        return;
      end
      if (taken < key_len) return;
      ones  = (1 << key_len) - 1;
      value = 32'(acc) & ones;
      taken = 0;
      acc   = '0;
      if (value == ones) begin
        // All-ones key closes the segment silently
        in_seg  = 1'b0;
        key_len = 0;
        return;
      end
      idx   = ones - key_len + value;
      r.ch  = (idx < fill) ? key_chars[idx] : '0;
      r.eom = 1'b0;
      expected_chars.push_back(r);
    endfunction

    // Compare one accepted result word with the oldest expectation
    function void check_result(char_t ch, logic eom);
      char_result_t want;
      if (expected_chars.size() == 0) begin
        $error("unexpected result: decoded_char %0h end_of_message %0b", ch, eom);
        errors++;
        return;
      end
      want = expected_chars.pop_front();
      results++;
      if (want.eom) eoms++;
      if (ch !== want.ch) begin
        $error("decoded_char mismatch: expected %0h, actual %0h", want.ch, ch);
        errors++;
      end
      if (eom !== want.eom) begin
        $error("end_of_message mismatch: expected %0b, actual %0b", want.eom, eom);
        errors++;
      end
    endfunction
  endclass

  logic  clk_i         = 1'b0;
  logic  rst_ni        = 1'b0;
  logic  in_valid_i    = 1'b0;
  logic  op_i          = 1'b0;
  char_t header_char_i = '0;
  logic  code_bit_i    = 1'b0;
  logic  out_ready_i   = 1'b0;
  logic  in_ready_o;
  logic  out_valid_o;
  char_t decoded_char_o;
  logic  end_of_message_o;

  key_decode_tracker tracker = new();

  int unsigned items_sent    = 0;
  int unsigned messages_sent = 0;
  int unsigned quiet_cycles  = 0;
  bit          steady_tx     = 1'b0;
  bit          hold_off_req  = 1'b0;
  bit          hold_off_done = 1'b0;

  length_prefixed_key_decoder_core u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .op_i             (op_i),
    .header_char_i    (header_char_i),
    .code_bit_i       (code_bit_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .decoded_char_o   (decoded_char_o),
    .end_of_message_o (end_of_message_o)
  );

  always #1 clk_i = ~clk_i;

  // Mostly short gaps, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Key lengths lean short, with the long ones still common
  function automatic int unsigned pick_len();
    return $urandom_range(1, ($urandom_range(0, 3) == 0) ? MaxKeyLen : 4);
  endfunction

  // Offer one word and hold it until accepted
  task automatic send_word(input op_e op, input char_t hc, input logic b);
    int unsigned gap;
    gap = steady_tx ? 0 : idle_len();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    op_i          <= op;
    header_char_i <= hc;
    code_bit_i    <= b;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.note_word(op, hc, b);
    items_sent++;
  endtask

  // Send n code bits of val, MSB first
  task automatic send_bits(input int unsigned val, input int unsigned n);
    for (int i = int'(n) - 1; i >= 0; i--) begin
      send_word(OP_CODE, char_t'($urandom), val[i]);
    end
  endtask

  task automatic send_header(input int unsigned n);
    repeat (n) send_word(OP_HEADER, char_t'($urandom), 1'($urandom));
  endtask

  // Prefix, a few keys (with stray header words), then the all-ones close
  task automatic send_segment(input int unsigned len, input int unsigned nkeys);
    send_bits(len, PrefixBits);
    repeat (nkeys) begin
      if ($urandom_range(0, 9) == 0) send_word(OP_HEADER, char_t'($urandom), 1'($urandom));
      send_bits($urandom_range(0, (1 << len) - 2), len);
    end
    send_bits((1 << len) - 1, len);
  endtask

  task automatic send_message(input int unsigned hdr_len, input int unsigned nseg);
    send_header(hdr_len);
    repeat (nseg) send_segment(pick_len(), $urandom_range(0, 5));
    send_bits(0, PrefixBits);
    messages_sent++;
  endtask

  // Receiver: random ready/stall runs, plus one long hold-off on request
  initial begin : rx_side
    int unsigned left;
    bit          ready_now;
    left      = 0;
    ready_now = 1'b1;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_req && !hold_off_done) begin
        hold_off_done = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
        left = 0;
      end else begin
        if (left == 0) begin
          if (!ready_now) begin
            ready_now = 1'b1;
            left      = $urandom_range(1, 24);
          end else begin
            left      = idle_len();
            ready_now = (left == 0);
            if (left == 0) left = $urandom_range(1, 24);
          end
        end
        left--;
        out_ready_i <= ready_now;
      end
    end
  end

  // Check every accepted result word
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      tracker.check_result(decoded_char_o, end_of_message_o);
    end
  end

  // Stop the run if neither channel moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("length_prefixed_key_decoder_core test failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int unsigned random_start;
    int unsigned roll;
    int unsigned msgs_at_start;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Load three entries, extremes of the character field
    send_word(OP_HEADER, 8'hFF, 1'b1);
    send_word(OP_HEADER, 8'h00, 1'b0);
    send_word(OP_HEADER, 8'hA5, 1'b1);
    // Length 1: key 0 reads entry 0, key 1 closes the segment
    send_bits(1, PrefixBits);
    send_bits(0, 1);
    send_bits(1, 1);
    // Length 2: key 00 reads a loaded entry, key 10 an unloaded one
    send_bits(2, PrefixBits);
    send_bits(0, 2);
    send_bits(2, 2);
    // Header word while decoding is ignored
    send_word(OP_HEADER, 8'h3C, 1'b0);
    send_bits(3, 2);
    send_bits(0, PrefixBits);
    // Decode again with no new header: every key reads zero
    send_bits(1, PrefixBits);
    send_bits(0, 1);
    send_bits(1, 1);
    send_bits(0, PrefixBits);
    messages_sent += 2;

    // Full table plus overflow, then hit the first and last length-7 entries
    random_start = items_sent;
    send_header(TotalKeys + 3);
    send_bits(MaxKeyLen, PrefixBits);
    send_bits(0, MaxKeyLen);
    send_bits((1 << MaxKeyLen) - 2, MaxKeyLen);
    send_bits((1 << MaxKeyLen) - 1, MaxKeyLen);
    send_segment(pick_len(), 4);
    send_bits(0, PrefixBits);
    messages_sent++;

    // Random messages, with some noise and truncated sequences
    msgs_at_start = messages_sent;
    while (items_sent < random_start + RandomItems) begin
      steady_tx = ($urandom_range(0, 4) == 0);
      if (messages_sent == msgs_at_start + 2) hold_off_req = 1'b1;
      roll = $urandom_range(0, 9);
      if (roll == 0) begin
        repeat ($urandom_range(4, 16)) begin
          send_word(op_e'($urandom_range(0, 1)), char_t'($urandom), 1'($urandom));
        end
      end else if (roll == 1) begin
        send_header($urandom_range(0, 6));
        send_bits(pick_len(), PrefixBits);
        repeat ($urandom_range(1, 10)) send_bits($urandom_range(0, 1), 1);
      end else begin
        send_message($urandom_range(0, 24), $urandom_range(1, 3));
      end
    end
    in_valid_i <= 1'b0;

    // Drain outstanding results, then watch for strays
    while (tracker.expected_chars.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d words over %0d messages, including a full table load and overflow.",
             items_sent, messages_sent);
    $display("Checked %0d result words, %0d of them end markers.", tracker.results, tracker.eoms);
    if (tracker.errors == 0) begin
      $display("length_prefixed_key_decoder_core test passed");
    end else begin
      $display("length_prefixed_key_decoder_core test failed");
    end
    $finish;
  end

endmodule

[files.f]
src/lpkd_pkg.sv
src/lpkd_key_table.sv
src/lpkd_bit_decoder.sv
src/length_prefixed_key_decoder_core.sv
tb/tb_length_prefixed_key_decoder_core.sv
